// ===== rtl/sorted_priority_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared assertion wrappers for the queue's checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Clocked assertion with an explicit disable condition.
`define SPQ_ASSERT_DIS(lbl, dis, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) prop) else $error(msg);

// Clocked assertion that is switched off while reset is high.
`define SPQ_ASSERT(lbl, prop, msg) \
  `SPQ_ASSERT_DIS(lbl, rst, prop, msg)

`endif

// ===== rtl/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Item types, action and status codes, and the control bundle sent to cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int KeyW = 16;
  localparam int IdW  = 16;
  localparam int OccW = 5;

  localparam logic [2:0] ACT_INSERT      = 3'd0;
  localparam logic [2:0] ACT_REMOVE_HEAD = 3'd1;
  localparam logic [2:0] ACT_REMOVE_TAIL = 3'd2;
  localparam logic [2:0] ACT_PEEK_HEAD   = 3'd3;
  localparam logic [2:0] ACT_CLEAR       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]             action;
    logic [IdW-1:0]         entry_id;
    logic signed [KeyW-1:0] entry_key;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [IdW-1:0]         result_id;
    logic signed [KeyW-1:0] result_key;
    logic [OccW-1:0]        occupancy;
  } spq_out_t;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    logic                   insert;
    logic                   pop_head;
    logic                   desc;
    logic signed [KeyW-1:0] key;
    logic [IdW-1:0]         id;
  } spq_cell_ctl_t;

endpackage

// ===== rtl/spq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the queue: compares its key with the new key, passes the scan
// state to its tail-side neighbor and shifts data on insert and head removal.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                          clk,
  input  spq_pkg::spq_cell_ctl_t        ctl,
  input  logic                          valid,
  input  logic                          seen_ge_in,
  input  logic                          before_in,
  input  logic signed [spq_pkg::KeyW-1:0] left_key,
  input  logic [spq_pkg::IdW-1:0]       left_id,
  input  logic signed [spq_pkg::KeyW-1:0] right_key,
  input  logic [spq_pkg::IdW-1:0]       right_id,
  output logic signed [spq_pkg::KeyW-1:0] key,
  output logic [spq_pkg::IdW-1:0]       id,
  output logic                          seen_ge_out,
  output logic                          before_out
);
  import spq_pkg::*;

  logic gt;
  logic lt;
  logic stop;

  assign gt = key > ctl.key;
  assign lt = key < ctl.key;

  // In ascending order the scan first skips lower keys, then a run of equal
  // keys, and ends at the first slot that breaks that pattern. In descending
  // order it ends at the first key that is not higher. An empty slot always
  // ends the scan.
  assign stop = !valid || (ctl.desc ? !gt : (gt || (lt && seen_ge_in)));
  assign seen_ge_out = seen_ge_in || (valid && !lt);
  assign before_out  = before_in || stop;

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (before_in) begin
        key <= left_key;
        id  <= left_id;
      end else if (stop) begin
        key <= ctl.key;
        id  <= ctl.id;
      end
    end else if (ctl.pop_head) begin
      key <= right_key;
      id  <= right_id;
    end
  end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue of (id, key) entries kept in order in a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on in_valid / in_stall / in_item; an item is taken at a clock
//   edge where in_valid is high and in_stall is low. Each item carries one
//   action: insert, remove head, remove tail, peek head or clear.
//   Every item produces exactly one result item on out_valid / out_stall /
//   out_item, in the cycle after it is taken, held in an output register.
//   One item is taken per cycle as long as the output side keeps up; in_stall
//   rises only while a result waits in the output register and the receiver
//   stalls it. The insert position is found in the same cycle by a ripple of
//   scan bits through the slot cells, which sets the clock period.
//   The order register is written on cfg_valid / cfg_ready (always ready) and
//   must only change while the queue is idle; held entries are not re-sorted.
//   Reset (synchronous, active high) empties the queue, clears the order bit
//   to ascending and drops any waiting result. Slot contents are not reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  spq_pkg::spq_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output spq_pkg::spq_out_t out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic                   descending_order;
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic                   accept;
  logic                   full;
  logic                   empty;
  spq_out_t               result;
  spq_cell_ctl_t          cell_ctl;

  logic signed [KeyW-1:0] cell_key [DEPTH];
  logic [IdW-1:0]         cell_id  [DEPTH];
  logic [DEPTH:0]         slot_valid;
  logic [DEPTH-1:0]       tail_sel;
  logic [DEPTH:0]         seen_ge;
  logic [DEPTH:0]         placed;
  logic signed [KeyW-1:0] tail_key;
  logic [IdW-1:0]         tail_id;

  // The configuration register is always ready to be written.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      descending_order <= 1'b0;
    end else if (cfg_valid) begin
      descending_order <= cfg_data;
    end
  end

  // The input side only waits when a finished result cannot leave.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign full  = count == CW'(DEPTH);
  assign empty = count == '0;

  assign cell_ctl.insert   = accept && (in_item.action == ACT_INSERT) && !full;
  assign cell_ctl.pop_head = accept && (in_item.action == ACT_REMOVE_HEAD) && !empty;
  assign cell_ctl.desc     = descending_order;
  assign cell_ctl.key      = in_item.entry_key;
  assign cell_ctl.id       = in_item.entry_id;

  // Scan state enters at the head; nothing has been seen there yet.
  assign seen_ge[0]        = 1'b0;
  assign placed[0]         = 1'b0;
  assign slot_valid[DEPTH] = 1'b0;

  for (genvar p = 0; p < DEPTH; p++) begin : g_cell
    localparam int LEFT  = (p == 0) ? 0 : p - 1;
    localparam int RIGHT = (p == DEPTH - 1) ? p : p + 1;

    assign slot_valid[p] = CW'(p) < count;
    // The tail is the last occupied slot.
    assign tail_sel[p]   = slot_valid[p] && !slot_valid[p+1];

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (cell_ctl),
      .valid       (slot_valid[p]),
      .seen_ge_in  (seen_ge[p]),
      .before_in   (placed[p]),
      .left_key    (cell_key[LEFT]),
      .left_id     (cell_id[LEFT]),
      .right_key   (cell_key[RIGHT]),
      .right_id    (cell_id[RIGHT]),
      .key         (cell_key[p]),
      .id          (cell_id[p]),
      .seen_ge_out (seen_ge[p+1]),
      .before_out  (placed[p+1])
    );
  end

  // One-hot selection of the tail slot.
  always_comb begin
    tail_key = '0;
    tail_id  = '0;
    for (int p = 0; p < DEPTH; p++) begin
      tail_key = tail_key | (tail_sel[p] ? cell_key[p] : '0);
      tail_id  = tail_id  | (tail_sel[p] ? cell_id[p]  : '0);
    end
  end

  // Result of the item on the input, and the occupancy it leaves behind.
  always_comb begin
    result     = '0;
    count_next = count;
    unique case (in_item.action)
      ACT_INSERT: begin
        if (full) begin
          result.status = ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      ACT_REMOVE_HEAD, ACT_PEEK_HEAD: begin
        if (empty) begin
          result.status = ST_EMPTY;
        end else begin
          result.result_id  = cell_id[0];
          result.result_key = cell_key[0];
          if (in_item.action == ACT_REMOVE_HEAD) begin
            count_next = count - CW'(1);
          end
        end
      end
      ACT_REMOVE_TAIL: begin
        if (empty) begin
          result.status = ST_EMPTY;
        end else begin
          result.result_id  = tail_id;
          result.result_key = tail_key;
          count_next        = count - CW'(1);
        end
      end
      ACT_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
    result.occupancy = OccW'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else if (accept) begin
      count     <= count_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= result;
    end
  end

endmodule

// ===== rtl/spq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Port-level assertions on the queue, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_macros.svh"

module spq_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input spq_pkg::spq_out_t out_item
);
  import spq_pkg::*;

  logic taken;
  logic held_out;
  logic err_out;
  logic no_entry;

  assign taken    = in_valid && !in_stall;
  assign held_out = out_valid && out_stall;
  assign err_out  = out_valid && (out_item.status != ST_OK);
  assign no_entry = (out_item.result_id == '0) && (out_item.result_key == '0);

  // Every taken item has its result ready in the next cycle.
  `SPQ_ASSERT(a_result_follows, taken |=> out_valid, "item without result")

  // A stalled result blocks the input side.
  `SPQ_ASSERT(a_stall_back, held_out |-> in_stall, "input taken over stalled result")

  // Empty and full results carry no entry.
  `SPQ_ASSERT(a_error_no_entry, err_out |-> no_entry, "entry reported with error status")

  // A stalled result holds.
  `SPQ_ASSERT(a_out_hold, held_out |=> (out_valid && $stable(out_item)), "stalled result changed")

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

// ===== bench/sorted_priority_queue_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Watches the action, result and order channels of the queue, keeps its own
// copy of the sorted slots, and compares every result item with the one that
// this copy predicts, in order.
// ----------------------------------------------------------------------------
module sorted_priority_queue_checker #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  spq_pkg::spq_in_t  in_item,
  input  logic              out_valid,
  input  logic              out_stall,
  input  spq_pkg::spq_out_t out_item,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_data,
  output int                mismatches,
  output int                outstanding
);

  import spq_pkg::*;

  logic signed [KeyW-1:0] slot_key [DEPTH];
  logic [IdW-1:0]         slot_id  [DEPTH];
  int                     held = 0;
  logic                   desc_order = 1'b0;
  spq_out_t               due_results [$];
  int                     errs = 0;

  // Applies one action to the model slots and returns the result it gives.
  function automatic spq_out_t apply_action(spq_in_t it);
    spq_out_t               r;
    int                     pos;
    logic signed [KeyW-1:0] k;
    r = '0;
    r.status = ST_OK;
    k = it.entry_key;
    case (it.action)
      ACT_INSERT: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          if (desc_order) begin
            while (pos < held && slot_key[pos] > k) pos++;
          end else begin
            while (pos < held && slot_key[pos] < k) pos++;
            while (pos < held && slot_key[pos] == k) pos++;
          end
          for (int i = held; i > pos; i--) begin
            slot_key[i] = slot_key[i-1];
            slot_id[i]  = slot_id[i-1];
          end
          slot_key[pos] = k;
          slot_id[pos]  = it.entry_id;
          held++;
        end
      end
      ACT_REMOVE_HEAD, ACT_PEEK_HEAD: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.result_id  = slot_id[0];
          r.result_key = slot_key[0];
          if (it.action == ACT_REMOVE_HEAD) begin
            for (int i = 1; i < held; i++) begin
              slot_key[i-1] = slot_key[i];
              slot_id[i-1]  = slot_id[i];
            end
            held--;
          end
        end
      end
      ACT_REMOVE_TAIL: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          held--;
          r.result_id  = slot_id[held];
          r.result_key = slot_key[held];
        end
      end
      ACT_CLEAR: begin
        held = 0;
      end
      default: begin
      end
    endcase
    r.occupancy = OccW'(held);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    spq_out_t want;
    if (rst) begin
      held = 0;
      desc_order = 1'b0;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) desc_order = cfg_data;
      if (in_valid && !in_stall) due_results.push_back(apply_action(in_item));
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: unexpected result: status %0d id %0h key %0d occ %0d",
                     $realtime, out_item.status, out_item.result_id, out_item.result_key,
                     out_item.occupancy);
        end else begin
          want = due_results.pop_front();
          if (out_item.status !== want.status || out_item.result_id !== want.result_id ||
              out_item.result_key !== want.result_key ||
              out_item.occupancy !== want.occupancy) begin
            errs++;
            if (errs <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected status %0d id %0h key %0d occ %0d",
                       want.status, want.result_id, want.result_key, want.occupancy);
              $display("  actual   status %0d id %0h key %0d occ %0d",
                       out_item.status, out_item.result_id, out_item.result_key,
                       out_item.occupancy);
            end
          end
        end
      end
    end
    mismatches  <= errs;
    outstanding <= due_results.size();
  end

endmodule

// ===== bench/tb_sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives actions into the queue under random sender gaps and receiver stalls,
// switches the sort order between phases, and takes the verdict from the
// checker that runs beside the queue.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;

  import spq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 750;
  localparam int CYCLE_LIMIT  = 200000;

  // Action codes that the queue treats as no operation.
  localparam logic [2:0] ACT_NOP_FIRST = 3'd5;
  localparam logic [2:0] ACT_NOP_LAST  = 3'd7;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  spq_in_t  in_item   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  spq_out_t out_item;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic     cfg_data  = 1'b0;

  int mismatches;
  int outstanding;
  int send_gap_pct = 23;
  int stall_pct    = 56;
  int cycles       = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sorted_priority_queue #(.DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  sorted_priority_queue_checker #(.DEPTH(DEPTH)) u_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // The receiver stalls the result channel at random, at the rate of the
  // current phase. A rate of zero turns the stalls off altogether.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_sorted_priority_queue: errors");
      $finish;
    end
  end

  // Offers one item and returns once it has been taken. Before the item goes
  // out the sender may first sit idle for a random gap. Valid is only lowered in a
  // cycle where it is not raised again, so each step sees one assignment.
  task automatic send(input logic [2:0] act, input logic [IdW-1:0] id,
                      input logic signed [KeyW-1:0] key);
    spq_in_t it;
    it.action    = act;
    it.entry_id  = id;
    it.entry_key = key;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // Holds the sender back until every result in flight has been received.
  // The checker's count is registered, so it is read only after an edge.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Changes the sort order only while no action is in flight. Entries that
  // the queue still holds stay where they are.
  task automatic write_order(input logic descending);
    drain();
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= descending;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Keys lean towards a handful of small values so that equal keys are
  // common, which is where the two orders differ in how ties are placed.
  function automatic logic signed [KeyW-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 40) return KeyW'(int'($urandom_range(4)) - 2);
    if (r < 55) begin
      case ($urandom_range(3))
        0:       return -32768;
        1:       return 32767;
        2:       return 0;
        default: return -1;
      endcase
    end
    return KeyW'($urandom());
  endfunction

  // One random action. While filling, inserts dominate so the queue runs up
  // against full; while draining, removals dominate so it runs down to empty.
  task automatic send_random(input bit filling);
    int         r;
    logic [2:0] act;
    r = $urandom_range(99);
    if (r < (filling ? 70 : 26))      act = ACT_INSERT;
    else if (r < (filling ? 76 : 50)) act = ACT_REMOVE_HEAD;
    else if (r < (filling ? 82 : 74)) act = ACT_REMOVE_TAIL;
    else if (r < 90)                  act = ACT_PEEK_HEAD;
    else if (r < 91)                  act = ACT_CLEAR;
    else act = ACT_NOP_FIRST + 3'($urandom_range(ACT_NOP_LAST - ACT_NOP_FIRST));
    send(act, IdW'($urandom()), pick_key());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Ascending order, written explicitly even though it is the reset value.
    write_order(1'b0);

    // Reads on an empty queue report empty; unused codes do nothing.
    send(ACT_PEEK_HEAD, 16'hFFFF, 32767);
    send(ACT_REMOVE_HEAD, 16'h0000, -32768);
    send(ACT_REMOVE_TAIL, 16'h5A5A, -1);
    send(ACT_NOP_FIRST, 16'h1234, 77);
    send(ACT_NOP_LAST, 16'hFFFF, -32768);

    // Key extremes first, then a run of tied keys to show first in, first
    // out among equals, until the queue is full and one more is turned away.
    send(ACT_INSERT, 16'hFFFF, 32767);
    send(ACT_INSERT, 16'h0000, -32768);
    for (int i = 2; i < DEPTH; i++) begin
      send(ACT_INSERT, IdW'(i), (i % 3 == 0) ? 0 : 5);
    end
    send(ACT_INSERT, 16'hABCD, 5);
    send(ACT_PEEK_HEAD, 16'h0000, 0);
    send(ACT_REMOVE_HEAD, 16'h0000, 0);
    send(ACT_REMOVE_TAIL, 16'h0000, 0);

    // Switch to descending with entries still held: they are not re-sorted,
    // and new ties go in front of older ones.
    write_order(1'b1);
    send(ACT_INSERT, 16'h0100, 5);
    send(ACT_INSERT, 16'h0101, 5);
    send(ACT_INSERT, 16'h0102, -1);
    send(ACT_REMOVE_HEAD, 16'h0000, 0);
    send(ACT_REMOVE_TAIL, 16'h0000, 0);
    send(ACT_CLEAR, 16'h0000, 0);

    // Three random phases: receiver stalls more than sender idles, then the
    // reverse, then neither holds back. The order is rewritten at each phase
    // change and once more in the middle of the last phase.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct = 23;
          stall_pct   <= 56;
        end
        1: begin
          send_gap_pct = 56;
          stall_pct   <= 23;
        end
        default: begin
          send_gap_pct = 0;
          stall_pct   <= 0;
        end
      endcase
      write_order(phase == 1);
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
        if (phase == 2 && n == RANDOM_ITEMS / 6) write_order(1'b1);
        // Now and then the sender waits for every result to come back.
        if ($urandom_range(79) == 0) drain();
        send_random((n / 40) % 2 == 0);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_sorted_priority_queue: clean");
    end else begin
      $display("tb_sorted_priority_queue: errors");
    end
    $finish;
  end

endmodule

// ===== sorted_priority_queue.f =====
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
bench/sorted_priority_queue_checker.sv
bench/tb_sorted_priority_queue.sv
